>>> rtl/core/lesb_pkg.sv
package lesb_pkg;

	localparam int PIXEL_W = 8;
	localparam int REPEAT_W = 14;
	localparam int LINE_WIDTH_W = 15;
	localparam int MAX_LINE_WIDTH_DEFAULT = 16384;

	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = LINE_WIDTH_W'(2048);
	localparam logic [PIXEL_W-1:0] BRIGHT = 8'hff;
	localparam logic [PIXEL_W-1:0] DARK = 8'h00;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_value;
		logic [REPEAT_W-1:0] repeat_count;
		logic line_end;
		logic last;
	} result_t;

endpackage

>>> rtl/core/lesb_step.sv
module lesb_step #(
	parameter int MAX_LINE_WIDTH = lesb_pkg::MAX_LINE_WIDTH_DEFAULT,
	parameter int COL_W = $clog2(MAX_LINE_WIDTH),
	parameter int PEND_W = $clog2(MAX_LINE_WIDTH + 1)
) (
	input  logic [lesb_pkg::LINE_WIDTH_W-1:0] line_width,
	input  logic [lesb_pkg::PIXEL_W-1:0] pixel,
	input  logic [COL_W-1:0] column,
	input  logic leading_open,
	input  logic [PEND_W-1:0] pending,
	output lesb_pkg::result_t res0,
	output logic res0_valid,
	output lesb_pkg::result_t res1,
	output logic res1_valid,
	output logic [COL_W-1:0] column_next,
	output logic leading_open_next,
	output logic [PEND_W-1:0] pending_next
);
	import lesb_pkg::*;

	localparam int WW = PEND_W;

	logic [WW-1:0] eff_width;
	logic [WW-1:0] half;
	logic [WW-1:0] col_w;
	logic [PEND_W-1:0] pending_inc;
	logic at_end;
	logic is_bright;

	always_comb begin
		if (line_width == '0) begin
			eff_width = WW'(1);
		end else if (32'(line_width) > MAX_LINE_WIDTH) begin
			eff_width = WW'(MAX_LINE_WIDTH);
		end else begin
			eff_width = WW'(line_width);
		end
	end

	assign half = eff_width >> 1;
	assign col_w = WW'(column);
	assign at_end = col_w >= (eff_width - WW'(1));
	assign is_bright = pixel == BRIGHT;
	assign pending_inc = pending + PEND_W'(1);

	always_comb begin
		res0.pixel_value = BRIGHT;
		res0.repeat_count = REPEAT_W'(pending);
		res0.line_end = 1'b0;
		res0.last = 1'b0;
		res0_valid = 1'b0;
		res1.pixel_value = pixel;
		res1.repeat_count = REPEAT_W'(1);
		res1.line_end = 1'b0;
		res1.last = 1'b1;
		res1_valid = 1'b1;
		leading_open_next = leading_open;
		pending_next = '0;

		if (col_w < half) begin
			res0_valid = pending != '0;
			if (leading_open && is_bright) begin
				res1.pixel_value = DARK;
			end else begin
				leading_open_next = 1'b0;
			end
		end else if (is_bright) begin
			pending_next = pending_inc;
			res1.pixel_value = DARK;
			res1.repeat_count = REPEAT_W'(pending_inc);
			res1.line_end = 1'b1;
			res1_valid = at_end;
		end else begin
			res0_valid = pending != '0;
			res1.line_end = at_end;
		end

		if (at_end) begin
			column_next = '0;
			leading_open_next = 1'b1;
			pending_next = '0;
		end else begin
			column_next = column + COL_W'(1);
		end
	end

endmodule

>>> rtl/core/line_edge_saturation_blanker.sv
// Blanks saturated pixels at both edges of each image line. Pixels arrive in raster
// order, one per transfer, and leave as runs of one value with a repeat count. A
// pixel is taken in every cycle as long as each pixel yields at most one run and
// the output is not stalled; a pixel that releases a held run of bright right-half
// pixels yields two runs, and since the output register hands out one run per cycle
// the next pixel then waits until the second run leaves. A bright pixel in the right
// half that is not at the line end yields nothing. A run passes from its pixel's
// transfer through an input register and a result register before it is offered at
// the output. The line width may be changed only while the block is idle; there is
// no start-up sweep after reset.
module line_edge_saturation_blanker #(
	parameter int MAX_LINE_WIDTH = lesb_pkg::MAX_LINE_WIDTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lesb_pkg::LINE_WIDTH_W-1:0] line_width,
	input  logic in_valid,
	output logic in_ready,
	input  logic [lesb_pkg::PIXEL_W-1:0] pixel,
	output logic out_valid,
	input  logic out_ready,
	output logic [lesb_pkg::PIXEL_W-1:0] pixel_value,
	output logic [lesb_pkg::REPEAT_W-1:0] repeat_count,
	output logic line_end,
	output logic last
);
	import lesb_pkg::*;

	localparam int COL_W = $clog2(MAX_LINE_WIDTH);
	localparam int PEND_W = $clog2(MAX_LINE_WIDTH + 1);

	logic [LINE_WIDTH_W-1:0] line_width_q;
	logic [PIXEL_W-1:0] pixel_s1;
	logic valid_s1;
	logic [COL_W-1:0] column_q;
	logic leading_open_q;
	logic [PEND_W-1:0] pending_q;
	result_t res0_s2;
	result_t res1_s2;
	logic res0_valid_s2;
	logic res1_valid_s2;

	result_t res0;
	result_t res1;
	logic res0_valid;
	logic res1_valid;
	logic [COL_W-1:0] column_next;
	logic leading_open_next;
	logic [PEND_W-1:0] pending_next;
	logic out_fire;
	logic free;
	logic advance;
	result_t shown;

	lesb_step #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH),
		.COL_W(COL_W),
		.PEND_W(PEND_W)
	) u_step (
		.line_width(line_width_q),
		.pixel(pixel_s1),
		.column(column_q),
		.leading_open(leading_open_q),
		.pending(pending_q),
		.res0(res0),
		.res0_valid(res0_valid),
		.res1(res1),
		.res1_valid(res1_valid),
		.column_next(column_next),
		.leading_open_next(leading_open_next),
		.pending_next(pending_next)
	);

	assign cfg_ready = 1'b1;

	assign out_valid = res0_valid_s2 | res1_valid_s2;
	assign out_fire = out_valid & out_ready;
	assign free = !out_valid || (out_fire && !(res0_valid_s2 && res1_valid_s2));
	assign advance = valid_s1 & free;
	assign in_ready = !valid_s1 || advance;

	assign shown = res0_valid_s2 ? res0_s2 : res1_s2;
	assign pixel_value = shown.pixel_value;
	assign repeat_count = shown.repeat_count;
	assign line_end = shown.line_end;
	assign last = shown.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			line_width_q <= line_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_s1 <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			leading_open_q <= 1'b1;
			pending_q <= '0;
		end else if (advance) begin
			column_q <= column_next;
			leading_open_q <= leading_open_next;
			pending_q <= pending_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res0_valid_s2 <= 1'b0;
			res1_valid_s2 <= 1'b0;
		end else if (advance) begin
			res0_valid_s2 <= res0_valid;
			res1_valid_s2 <= res1_valid;
		end else if (out_fire) begin
			if (res0_valid_s2) begin
				res0_valid_s2 <= 1'b0;
			end else begin
				res1_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res0_s2 <= res0;
			res1_s2 <= res1;
		end
	end

`ifndef ASSERT_OFF
	a_release_has_follower: assert property (@(posedge clk) disable iff (!arst_n)
		res0_valid_s2 |-> res1_valid_s2)
		else $error("A released bright run is not followed by the pixel that released it.");

	a_release_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res0_valid_s2 |-> (res0_s2.pixel_value == BRIGHT && !res0_s2.line_end
			&& !res0_s2.last && res0_s2.repeat_count != '0))
		else $error("A released bright run has the wrong value or flags.");

	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		res1_valid_s2 |-> res1_s2.last)
		else $error("The closing result of a pixel is not marked last.");

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pending_q) <= 32'(column_q))
		else $error("The held bright run is longer than the pixels seen in this line.");
`endif

endmodule
